@@ rtl/itfb_pkg.sv @@
// Shared types and constants for the IMU telemetry frame builder.
// Depends on nothing; every module of the block imports it.
package itfb_pkg;

   // Frame constants
   localparam logic [7:0] FRAME_HEADER  = 8'hAB;
   localparam logic [7:0] ID_ANGLES     = 8'h03;
   localparam logic [7:0] ID_RAW        = 8'h01;
   localparam logic [7:0] LEN_ANGLES    = 8'd7;
   localparam logic [7:0] LEN_RAW       = 8'd13;
   localparam logic [7:0] LEN_HIGH      = 8'h00;

   // Register reset values
   localparam logic [7:0] RESET_SOURCE  = 8'hDD;
   localparam logic [7:0] RESET_DEST    = 8'hFE;
   localparam logic [7:0] RESET_STATUS  = 8'h01;

   // Register indexes
   localparam int         CSR_INDEX_W   = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATUS = 2'd2;

   // Frame kinds
   localparam logic FUNC_ANGLES = 1'b0;
   localparam logic FUNC_RAW    = 1'b1;

   // Byte positions within a frame
   localparam int         POS_W          = 5;
   localparam logic [POS_W-1:0] POS_HEADER     = 5'd0;
   localparam logic [POS_W-1:0] POS_SOURCE     = 5'd1;
   localparam logic [POS_W-1:0] POS_DEST       = 5'd2;
   localparam logic [POS_W-1:0] POS_ID         = 5'd3;
   localparam logic [POS_W-1:0] POS_LEN_LOW    = 5'd4;
   localparam logic [POS_W-1:0] POS_LEN_HIGH   = 5'd5;
   localparam logic [POS_W-1:0] POS_PAYLOAD    = 5'd6;
   localparam logic [POS_W-1:0] POS_STATUS_ANG = 5'd12;
   localparam logic [POS_W-1:0] POS_STATUS_RAW = 5'd18;
   localparam logic [POS_W-1:0] POS_LAST_RAW   = 5'd20;

   // Angle scaling
   localparam int         PROD_W      = 31;
   localparam logic signed [PROD_W-1:0] ANGLE_SCALE = 31'sd100;
   localparam logic signed [PROD_W-1:0] TRUNC_BIAS  = 31'sd255;

   // Command queue between front and back
   localparam int NUM_VALS    = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                func;
      logic signed [23:0]  roll_angle;
      logic signed [23:0]  pitch_angle;
      logic signed [23:0]  yaw_angle;
      logic signed [15:0]  accel_x;
      logic signed [15:0]  accel_y;
      logic signed [15:0]  accel_z;
      logic signed [15:0]  gyro_x;
      logic signed [15:0]  gyro_y;
      logic signed [15:0]  gyro_z;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } rsp_type;

   // One classified frame: kind plus the 16-bit words in send order
   typedef struct packed {
      logic                         func;
      logic [NUM_VALS-1:0][15:0]    vals;
   } cmd_type;

   typedef struct packed {
      logic [7:0] source_address;
      logic [7:0] dest_address;
      logic [7:0] status_byte;
   } cfg_type;

   // Queue handshake between front, queue and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ rtl/itfb_front.sv @@
// Front end: accepts requests, scales angles and builds frame commands.
// Depends on itfb_pkg.
module itfb_front
   import itfb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  qstat_type q_stat,
   output logic      push,
   output cmd_type   push_cmd
);

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_func_ff;
   logic signed [2:0][PROD_W-1:0] s1_prod_ff, s1_prod_in;
   logic [NUM_VALS-1:0][15:0]     s1_raw_ff;
   logic signed [2:0][PROD_W-1:0] ang_ext;
   logic signed [2:0][PROD_W-1:0] adj;
   logic                          load;

   assign req_stall = s1_valid_ff && q_stat.full;
   assign load      = !req_stall;
   assign push      = s1_valid_ff && !q_stat.full;

   always_comb begin
      ang_ext[0] = PROD_W'(req_data.roll_angle);
      ang_ext[1] = PROD_W'(req_data.pitch_angle);
      ang_ext[2] = PROD_W'(req_data.yaw_angle);
      for (int i = 0; i < 3; i++) begin
         s1_prod_in[i] = ang_ext[i] * ANGLE_SCALE;
      end
      s1_valid_in = load ? req_valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (load && req_valid) begin
         s1_func_ff   <= req_data.func;
         s1_prod_ff   <= s1_prod_in;
         s1_raw_ff[0] <= req_data.accel_x;
         s1_raw_ff[1] <= req_data.accel_y;
         s1_raw_ff[2] <= req_data.accel_z;
         s1_raw_ff[3] <= req_data.gyro_x;
         s1_raw_ff[4] <= req_data.gyro_y;
         s1_raw_ff[5] <= req_data.gyro_z;
      end
   end

   // Divide by 256 with truncation toward zero: bias negatives, then shift
   always_comb begin
      push_cmd.func = s1_func_ff;
      push_cmd.vals = s1_raw_ff;
      for (int i = 0; i < 3; i++) begin
         adj[i] = s1_prod_ff[i] + (s1_prod_ff[i][PROD_W-1] ? TRUNC_BIAS : '0);
      end
      if (s1_func_ff == FUNC_ANGLES) begin
         for (int i = 0; i < 3; i++) begin
            push_cmd.vals[i] = adj[i][23:8];
         end
      end
   end

endmodule

@@ rtl/itfb_queue.sv @@
// Short command queue decoupling the front end from the serialiser.
// Depends on itfb_pkg.
module itfb_queue
   import itfb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_cmd,
   input  logic      pop,
   output cmd_type   pop_cmd,
   output qstat_type q_stat
);

   cmd_type [QUEUE_DEPTH-1:0] mem_ff;
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_cmd      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !pop)
      else $error("pop from an empty queue");

endmodule

@@ rtl/itfb_back.sv @@
// Back end: serialises one frame command per frame, adds both check bytes.
// Depends on itfb_pkg.
module itfb_back
   import itfb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  qstat_type q_stat,
   input  cmd_type   pop_cmd,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic             busy_ff, busy_in;
   cmd_type          cmd_ff;
   logic [POS_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in, add_ff, add_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             out_free, emit, is_last;
   logic [POS_W-1:0] status_pos, k;
   logic [2:0]       val_sel;
   logic [15:0]      val;
   logic [7:0]       byte_sel;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign emit       = busy_ff && out_free;
   assign status_pos = (cmd_ff.func == FUNC_RAW) ? POS_STATUS_RAW : POS_STATUS_ANG;
   assign is_last    = (idx_ff == status_pos + POS_W'(2));
   assign pop        = !q_stat.empty && (!busy_ff || (emit && is_last));
   assign k          = idx_ff - POS_PAYLOAD;
   assign val_sel    = k[3:1];

   always_comb begin
      case (val_sel)
         3'd0:    val = cmd_ff.vals[0];
         3'd1:    val = cmd_ff.vals[1];
         3'd2:    val = cmd_ff.vals[2];
         3'd3:    val = cmd_ff.vals[3];
         3'd4:    val = cmd_ff.vals[4];
         3'd5:    val = cmd_ff.vals[5];
         default: val = '0;
      endcase
   end

   always_comb begin
      if (idx_ff == POS_HEADER) begin
         byte_sel = FRAME_HEADER;
      end else if (idx_ff == POS_SOURCE) begin
         byte_sel = cfg.source_address;
      end else if (idx_ff == POS_DEST) begin
         byte_sel = cfg.dest_address;
      end else if (idx_ff == POS_ID) begin
         byte_sel = (cmd_ff.func == FUNC_RAW) ? ID_RAW : ID_ANGLES;
      end else if (idx_ff == POS_LEN_LOW) begin
         byte_sel = (cmd_ff.func == FUNC_RAW) ? LEN_RAW : LEN_ANGLES;
      end else if (idx_ff == POS_LEN_HIGH) begin
         byte_sel = LEN_HIGH;
      end else if (idx_ff < status_pos) begin
         byte_sel = k[0] ? val[15:8] : val[7:0];
      end else if (idx_ff == status_pos) begin
         byte_sel = cfg.status_byte;
      end else if (idx_ff == status_pos + POS_W'(1)) begin
         byte_sel = sum_ff;
      end else begin
         byte_sel = add_ff;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      sum_in  = sum_ff;
      add_in  = add_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
         sum_in  = '0;
         add_in  = '0;
      end else if (emit) begin
         // checksum bytes themselves never enter the sums
         idx_in = idx_ff + POS_W'(1);
         if (idx_ff <= status_pos) begin
            sum_in = sum_ff + byte_sel;
            add_in = add_ff + sum_ff + byte_sel;
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      out_valid_in = out_free ? emit : out_valid_ff;
      out_in.frame_byte = byte_sel;
      out_in.frame_last = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      add_ff <= add_in;
      if (pop) begin
         cmd_ff <= pop_cmd;
      end
      if (out_free) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= POS_LAST_RAW)
      else $error("byte position past the end of a raw frame");

   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cmd_ff.func == FUNC_ANGLES) |-> idx_ff <= POS_STATUS_ANG + POS_W'(2))
      else $error("byte position past the end of an angle frame");

   assert property (@(posedge clock) disable iff (reset)
      (emit && is_last) |=> (!busy_ff || idx_ff == '0))
      else $error("serialiser did not finish or restart after last byte");

endmodule

@@ rtl/imu_telemetry_frame_builder.sv @@
// IMU telemetry frame builder: request in, framed byte run out.
// Path: a request passes the front register and the queue into the serialiser.
// Throughput: one byte per cycle while rsp_stall is low; an angle frame is 15
// bytes and a raw frame 21.
// Reset (synchronous, active high) empties the pipeline and queue and
// restores source 0xDD, destination 0xFE and status 0x01.
module imu_telemetry_frame_builder
   import itfb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // result channel, one byte per transfer
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   qstat_type q_stat;
   logic      push, pop;
   cmd_type   push_cmd, pop_cmd;

   // Registers are always writable; writes to an unused index are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOURCE: cfg_in.source_address = csr_wdata;
            CSR_DEST:   cfg_in.dest_address   = csr_wdata;
            CSR_STATUS: cfg_in.status_byte    = csr_wdata;
            default:    cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_address <= RESET_SOURCE;
         cfg_ff.dest_address   <= RESET_DEST;
         cfg_ff.status_byte    <= RESET_STATUS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take the request, scale angles to hundredths, hand over a command
   itfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // Queue: hold up to two commands so each side can stall on its own
   itfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   // Back: serialise header, payload, status and the two check bytes
   itfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for imu_telemetry_frame_builder: drives telemetry requests and
// register writes, and predicts and checks every framed byte that comes out.
// Depends on itfb_pkg and the imu_telemetry_frame_builder top level only.
module tb_top;
   import itfb_pkg::*;

   // Index past the last register; a write to it must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int RANDOM_PHASES   = 4;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int REQ_W           = $bits(req_type);

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   // Register values as the block should hold them
   logic [7:0] frame_src_addr = RESET_SOURCE;
   logic [7:0] frame_dst_addr = RESET_DEST;
   logic [7:0] frame_status   = RESET_STATUS;

   // Bytes still owed by the block, oldest first
   rsp_type frame_bytes_due[$];

   // Idling controls in percent, set per test, and the countdown of the current stall setting
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int stall_left    = 0;

   int mismatches    = 0;
   int bytes_checked = 0;
   int angle_frames  = 0;
   int raw_frames    = 0;
   int reg_writes    = 0;

   imu_telemetry_frame_builder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: generous against the slowest legal run (every byte held by
   // the longest stall, every request behind the longest gap)
   initial begin
      #15_000_000;
      $display("imu_telemetry_frame_builder verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatches++;
   endtask

   // Idle length: zero unless the percentage hits, otherwise random, and now and then
   // a long one that spans most of a frame or more
   function automatic int idle_length(input int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(12, 30);
      return $urandom_range(1, 3);
   endfunction

   // Q16.8 degrees to hundredths, truncated toward zero, wrapped to 16 bits
   function automatic logic [15:0] centidegrees(input logic signed [23:0] angle);
      longint product;
      longint mag;
      product = longint'(angle) * 100;
      mag     = (product < 0) ? -product : product;
      mag     = mag >> 8;
      if (product < 0)
         mag = -mag;
      return 16'(mag);
   endfunction

   // Build the whole frame for one request and queue its bytes in send order
   function automatic void predict_frame(input req_type item);
      logic [7:0]  body[$];
      logic [15:0] words[$];
      logic [7:0]  run_sum;
      logic [7:0]  sum_of_sums;
      rsp_type     b;
      run_sum     = 8'h00;
      sum_of_sums = 8'h00;
      if (item.func == FUNC_RAW) begin
         words = '{item.accel_x, item.accel_y, item.accel_z,
                   item.gyro_x, item.gyro_y, item.gyro_z};
         body  = '{FRAME_HEADER, frame_src_addr, frame_dst_addr, ID_RAW, LEN_RAW, LEN_HIGH};
      end else begin
         words = '{centidegrees(item.roll_angle), centidegrees(item.pitch_angle),
                   centidegrees(item.yaw_angle)};
         body  = '{FRAME_HEADER, frame_src_addr, frame_dst_addr, ID_ANGLES, LEN_ANGLES,
                   LEN_HIGH};
      end
      foreach (words[i]) begin
         body.push_back(words[i][7:0]);
         body.push_back(words[i][15:8]);
      end
      body.push_back(frame_status);
      foreach (body[i]) begin
         run_sum     = run_sum + body[i];
         sum_of_sums = sum_of_sums + run_sum;
      end
      body.push_back(run_sum);
      body.push_back(sum_of_sums);
      foreach (body[i]) begin
         b.frame_byte = body[i];
         b.frame_last = (i == body.size() - 1);
         frame_bytes_due.push_back(b);
      end
   endfunction

   // Offer one request after a random gap; hold it until the transfer, then
   // leave valid high so that a following request can go back to back
   task automatic send_request(input req_type item);
      int gap;
      gap = idle_length(req_gap_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frame(item);
      if (item.func == FUNC_RAW)
         raw_frames++;
      else
         angle_frames++;
   endtask

   // Drop valid and wait until every owed byte has come out
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_SOURCE: frame_src_addr = value;
         CSR_DEST:   frame_dst_addr = value;
         CSR_STATUS: frame_status   = value;
         default: ;
      endcase
      reg_writes++;
   endtask

   // Reprogram all three registers while the block is idle, then poke the
   // unused index with junk, which must leave them untouched
   task automatic program_registers(input logic [7:0] src, input logic [7:0] dst,
                                    input logic [7:0] status);
      wait_until_idle();
      write_register(CSR_SOURCE, src);
      write_register(CSR_DEST, dst);
      write_register(CSR_STATUS, status);
      write_register(CSR_UNUSED, 8'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic req_type angle_request(input logic signed [23:0] roll,
                                             input logic signed [23:0] pitch,
                                             input logic signed [23:0] yaw);
      req_type r;
      r             = req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom}));
      r.func        = FUNC_ANGLES;
      r.roll_angle  = roll;
      r.pitch_angle = pitch;
      r.yaw_angle   = yaw;
      return r;
   endfunction

   function automatic req_type raw_request(input logic [15:0] ax, input logic [15:0] ay,
                                           input logic [15:0] az, input logic [15:0] gx,
                                           input logic [15:0] gy, input logic [15:0] gz);
      req_type r;
      r         = req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom}));
      r.func    = FUNC_RAW;
      r.accel_x = ax;
      r.accel_y = ay;
      r.accel_z = az;
      r.gyro_x  = gx;
      r.gyro_y  = gy;
      r.gyro_z  = gz;
      return r;
   endfunction

   // Angles: full range, plausible attitudes, values either side of the
   // 16-bit wrap of the hundredths, and the corner codes
   function automatic logic signed [23:0] random_angle();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = int'($urandom_range(0, 92160)) - 46080;
         2: v = ($urandom_range(0, 1) ? 167772 : -167772) + int'($urandom_range(0, 600)) - 300;
         default: begin
            case ($urandom_range(0, 4))
               0: v = 0;
               1: v = 1;
               2: v = -1;
               3: v = 8388607;
               default: v = -8388608;
            endcase
         end
      endcase
      return 24'(v);
   endfunction

   // Random kind and raw samples over the whole word, shaped angles
   function automatic req_type random_request();
      req_type r;
      r             = req_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom}));
      r.roll_angle  = random_angle();
      r.pitch_angle = random_angle();
      r.yaw_angle   = random_angle();
      return r;
   endfunction

   // Result side: random stall bursts, driven once per edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = idle_length(100) - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end
   end

   // Check every byte transfer against the oldest owed byte
   always @(posedge clock) begin : check_bytes
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_due.size() == 0) begin
            report_mismatch($sformatf("byte %02h with nothing owed", rsp_data.frame_byte));
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_data.frame_byte !== want.frame_byte)
               report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                         rsp_data.frame_byte, want.frame_byte));
            if (rsp_data.frame_last !== want.frame_last)
               report_mismatch($sformatf("frame_last %b on byte %02h, expected %b",
                                         rsp_data.frame_last, want.frame_byte,
                                         want.frame_last));
            bytes_checked++;
         end
      end
   end

   // Frames with the register values left by reset
   task automatic test_reset_defaults();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      send_request(angle_request(24'sd2560, -24'sd2560, 24'sd0));
      send_request(raw_request(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 16'hF0F0));
   endtask

   // Angle conversion: truncation toward zero, the wrap, the extremes; the
   // raw fields carry junk that must be ignored
   task automatic test_angle_corners();
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      send_request(angle_request(24'sd0, 24'sd1, -24'sd1));
      send_request(angle_request(-24'sd3, 24'sd3, 24'sd256));
      send_request(angle_request(-24'sd256, 24'sd255, -24'sd255));
      send_request(angle_request(24'sh7FFFFF, 24'sh800000, -24'sd8388607));
      send_request(angle_request(24'sd167772, -24'sd167772, 24'sd167773));
      send_request(angle_request(24'sd46080, -24'sd46080, 24'sd23040));
   endtask

   // Raw samples at the corners; the angle fields carry junk
   task automatic test_raw_corners();
      req_gap_pct   = 10;
      rsp_stall_pct = 10;
      send_request(raw_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_request(raw_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_request(raw_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      send_request(raw_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_request(raw_request(16'h0102, 16'h0304, 16'h0506, 16'h0708, 16'h090A, 16'h0B0C));
      send_request(raw_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
   endtask

   // Register extremes, each with both frame kinds, and one random setting with random frames
   task automatic test_register_settings();
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      program_registers(8'h00, 8'h00, 8'h00);
      send_request(angle_request(24'sd1000, -24'sd1000, 24'sd77));
      send_request(raw_request(16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00));
      program_registers(8'hFF, 8'hFF, 8'hFF);
      send_request(angle_request(-24'sd1000, 24'sd1000, -24'sd77));
      send_request(raw_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      program_registers(8'($urandom), 8'($urandom), 8'($urandom));
      send_request(random_request());
      send_request(random_request());
   endtask

   // Random traffic in phases, each with its own registers and idling:
   // moderate, none at all, heavy, and stall-biased
   task automatic test_random_traffic();
      int gap_pct[RANDOM_PHASES]   = '{30, 0, 70, 20};
      int stall_pct[RANDOM_PHASES] = '{30, 0, 70, 50};
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            1: program_registers(8'h00, 8'hFF, 8'h00);
            2: program_registers(8'hFF, 8'h00, 8'hFF);
            default: program_registers(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         req_gap_pct   = gap_pct[phase];
         rsp_stall_pct = stall_pct[phase];
         repeat (ITEMS_PER_PHASE) send_request(random_request());
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SOURCE;
      csr_wdata = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_angle_corners();
      test_raw_corners();
      test_register_settings();
      test_random_traffic();

      // Drain, then wait with stalls off so that any stray byte is caught
      wait_until_idle();
      rsp_stall_pct = 0;
      repeat (20) @(posedge clock);

      $display("Covered %0d angle and %0d raw frames, %0d bytes checked, %0d register writes.",
               angle_frames, raw_frames, bytes_checked, reg_writes);
      $display("Mismatches: %0d", mismatches);
      if (mismatches == 0)
         $display("imu_telemetry_frame_builder verification clean");
      else
         $display("imu_telemetry_frame_builder verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/itfb_pkg.sv
rtl/itfb_front.sv
rtl/itfb_queue.sv
rtl/itfb_back.sv
rtl/imu_telemetry_frame_builder.sv
test/tb_top.sv
